// ----- hdl/lirs_pkg.sv -----
package lirs_pkg;

  // word widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned POS_W    = RATE_W + 1;
  localparam int unsigned OFS_W    = 14;
  localparam int unsigned BASE_W   = 31;
  localparam int unsigned NUM_W    = 32;
  localparam int unsigned MUL_W    = 25;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned Y_W      = 23;
  localparam int unsigned QM_W     = Y_W + 1;
  localparam int unsigned Q_W      = 17;
  localparam int unsigned SQ_W     = Q_W + 1;

  // target rate split into power of two times odd factor
  localparam int unsigned TARGET_SHIFT = 7;
  localparam int unsigned TARGET_ODD   = 125;
  localparam int unsigned TARGET_RATE  = TARGET_ODD << TARGET_SHIFT;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
  localparam logic [RATE_W-1:0] MIN_RATE   = RATE_W'((TARGET_RATE + 15) / 16);
  localparam logic [POS_W-1:0]  POS_TARGET = POS_W'(TARGET_RATE);
  localparam logic [NUM_W-1:0]  HALF_TARGET = NUM_W'(TARGET_RATE / 2);

  // reciprocal of the odd factor, one correction step after the multiply
  localparam int unsigned       RECIP_SHIFT = 30;
  localparam int unsigned       RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_MUL  = RECIP_W'((64'd1 << RECIP_SHIFT) / TARGET_ODD);

  localparam logic signed [BASE_W-1:0] BASE_TARGET = BASE_W'(TARGET_RATE);
  localparam logic [QM_W-1:0]          QM_ODD      = QM_W'(TARGET_ODD);
  localparam logic signed [SQ_W-1:0]   SAT_HI      = SQ_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SQ_W-1:0]   SAT_LO      = -SAT_HI - SQ_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_MUL1,
    ST_ADD,
    ST_MUL2,
    ST_FIX,
    ST_TAIL
  } state_t;

endpackage

// ----- hdl/linear_interp_resampler.sv -----
// an interpolated result passes states PAIR, MUL1, ADD, MUL2 and FIX into the output register;
// a tail word goes through TAIL alone. An input word gives P interpolated and T tail results,
// the empty-tail marker counting in T, each at most 16; the shared multiplier is used twice
// per interpolated word
// input stall stays high until every result word of the current input is in the output register
// reset (rst_n low, synchronous): input_rate back to 48000, stream state cleared, output empty
module linear_interp_resampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lirs_pkg::RATE_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_end_of_stream,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lirs_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_valid_sample,
  output logic                                out_last_out
);

  // sequencer and handshake
  lirs_pkg::state_t state_r, state_nxt;
  logic in_acc;
  logic slot_free;

  // configuration and stream state
  logic [lirs_pkg::RATE_W-1:0]         rate_r;
  logic [lirs_pkg::RATE_W-1:0]         rate_eff;
  logic signed [lirs_pkg::SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                                have_prev_r, have_prev_nxt;
  logic [lirs_pkg::POS_W-1:0]          pos_r, pos_nxt;

  // per word working registers
  logic signed [lirs_pkg::SAMPLE_W-1:0] cur_r, cur_nxt;
  logic                                eos_r, eos_nxt;
  logic signed [lirs_pkg::BASE_W-1:0]  base_r, base_nxt;
  logic signed [lirs_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [lirs_pkg::Y_W-1:0]            y_r, y_nxt;
  logic                                neg_r, neg_nxt;

  // output register
  logic                                out_valid_r, out_valid_nxt;
  logic signed [lirs_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                                out_vs_r, out_vs_nxt;
  logic                                out_last_r, out_last_nxt;

  // shared multiplier
  logic signed [lirs_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*lirs_pkg::MUL_W-1:0] mul_p;

  // datapath intermediates
  logic signed [lirs_pkg::SAMPLE_W:0]  diff;
  logic signed [lirs_pkg::NUM_W-1:0]   num;
  logic [lirs_pkg::NUM_W-1:0]          mag;
  logic [lirs_pkg::Q_W-1:0]            q0, q;
  logic [lirs_pkg::QM_W-1:0]           q_mul, rem;
  logic signed [lirs_pkg::SQ_W-1:0]    sq, sq_sat;
  logic [lirs_pkg::POS_W-1:0]          pos_step;
  logic                                pos_low, step_low;

  assign in_stall  = (state_r != lirs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // rates under the floor are lifted to it, which caps each phase at 16 words
  assign rate_eff = (rate_r < lirs_pkg::MIN_RATE) ? lirs_pkg::MIN_RATE : rate_r;
  assign pos_step = pos_r + lirs_pkg::POS_W'(rate_eff);
  assign pos_low  = pos_r < lirs_pkg::POS_TARGET;
  assign step_low = pos_step < lirs_pkg::POS_TARGET;

  // slope between the neighbors, one bit wider than a sample
  assign diff = {cur_r[lirs_pkg::SAMPLE_W-1], cur_r} - {prev_r[lirs_pkg::SAMPLE_W-1], prev_r};

  // the one multiplier: slope times offset, then quotient estimate by reciprocal
  always_comb begin
    if (state_r == lirs_pkg::ST_MUL1) begin
      mul_a = lirs_pkg::MUL_W'(diff);
      mul_b = $signed({{(lirs_pkg::MUL_W-lirs_pkg::OFS_W){1'b0}}, pos_r[lirs_pkg::OFS_W-1:0]});
    end else begin
      mul_a = $signed({{(lirs_pkg::MUL_W-lirs_pkg::Y_W){1'b0}}, y_r});
      mul_b = $signed({{(lirs_pkg::MUL_W-lirs_pkg::RECIP_W){1'b0}}, lirs_pkg::RECIP_MUL});
    end
  end
  assign mul_p = mul_a * mul_b;

  // numerator prev*T + slope*r, then magnitude plus half for round half away from zero
  assign num = $signed({base_r[lirs_pkg::BASE_W-1], base_r}) + prod_r[lirs_pkg::NUM_W-1:0];
  assign mag = (num[lirs_pkg::NUM_W-1] ? lirs_pkg::NUM_W'(-num) : lirs_pkg::NUM_W'(num))
               + lirs_pkg::HALF_TARGET;

  // estimate is exact or one low; a single compare fixes it
  assign q0    = prod_r[lirs_pkg::RECIP_SHIFT +: lirs_pkg::Q_W];
  assign q_mul = lirs_pkg::QM_W'(q0) * lirs_pkg::QM_ODD;
  assign rem   = {1'b0, y_r} - q_mul;
  assign q     = (rem >= lirs_pkg::QM_ODD) ? q0 + lirs_pkg::Q_W'(1) : q0;
  assign sq    = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_comb begin
    if (sq > lirs_pkg::SAT_HI) begin
      sq_sat = lirs_pkg::SAT_HI;
    end else if (sq < lirs_pkg::SAT_LO) begin
      sq_sat = lirs_pkg::SAT_LO;
    end else begin
      sq_sat = sq;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lirs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (have_prev_r) begin
            state_nxt = lirs_pkg::ST_PAIR;
          end else if (in_end_of_stream) begin
            state_nxt = lirs_pkg::ST_TAIL;
          end
        end
      end
      lirs_pkg::ST_PAIR: begin
        if (pos_low) begin
          state_nxt = lirs_pkg::ST_MUL1;
        end else if (eos_r) begin
          state_nxt = lirs_pkg::ST_TAIL;
        end else begin
          state_nxt = lirs_pkg::ST_IDLE;
        end
      end
      lirs_pkg::ST_MUL1: state_nxt = lirs_pkg::ST_ADD;
      lirs_pkg::ST_ADD:  state_nxt = lirs_pkg::ST_MUL2;
      lirs_pkg::ST_MUL2: state_nxt = lirs_pkg::ST_FIX;
      lirs_pkg::ST_FIX: begin
        if (slot_free) begin
          state_nxt = lirs_pkg::ST_PAIR;
        end
      end
      lirs_pkg::ST_TAIL: begin
        if (slot_free && (!pos_low || !step_low)) begin
          state_nxt = lirs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lirs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    eos_nxt        = eos_r;
    base_nxt       = base_r;
    prod_nxt       = prod_r;
    y_nxt          = y_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_vs_nxt     = out_vs_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      lirs_pkg::ST_IDLE: begin
        if (in_acc) begin
          cur_nxt  = in_sample_in;
          eos_nxt  = in_end_of_stream;
          base_nxt = lirs_pkg::BASE_W'(prev_r) * lirs_pkg::BASE_TARGET;
          // first word of a stream only becomes the lower neighbor
          if (!have_prev_r && !in_end_of_stream) begin
            prev_nxt      = in_sample_in;
            have_prev_nxt = 1'b1;
          end
        end
      end
      lirs_pkg::ST_PAIR: begin
        if (!pos_low) begin
          // phase done: offset now counts from the current word
          pos_nxt = pos_r - lirs_pkg::POS_TARGET;
          if (!eos_r) begin
            prev_nxt      = cur_r;
            have_prev_nxt = 1'b1;
          end
        end
      end
      lirs_pkg::ST_MUL1: begin
        prod_nxt = lirs_pkg::PROD_W'(mul_p);
      end
      lirs_pkg::ST_ADD: begin
        neg_nxt = num[lirs_pkg::NUM_W-1];
        y_nxt   = mag[lirs_pkg::TARGET_SHIFT +: lirs_pkg::Y_W];
      end
      lirs_pkg::ST_MUL2: begin
        prod_nxt = lirs_pkg::PROD_W'(mul_p);
      end
      lirs_pkg::ST_FIX: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = lirs_pkg::SAMPLE_W'(sq_sat);
          out_vs_nxt     = 1'b1;
          out_last_nxt   = 1'b0;
          pos_nxt        = pos_step;
        end
      end
      lirs_pkg::ST_TAIL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (pos_low) begin
            // tail words hold the final sample
            out_sample_nxt = cur_r;
            out_vs_nxt     = 1'b1;
            out_last_nxt   = !step_low;
            pos_nxt        = pos_step;
          end else begin
            // empty tail: marker word with no sample
            out_sample_nxt = '0;
            out_vs_nxt     = 1'b0;
            out_last_nxt   = 1'b1;
          end
          if (!pos_low || !step_low) begin
            prev_nxt      = '0;
            have_prev_nxt = 1'b0;
            pos_nxt       = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lirs_pkg::ST_IDLE;
      rate_r      <= lirs_pkg::RATE_RESET;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    eos_r        <= eos_nxt;
    base_r       <= base_nxt;
    prod_r       <= prod_nxt;
    y_r          <= y_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_vs_r     <= out_vs_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_valid_sample = out_vs_r;
  assign out_last_out     = out_last_r;

endmodule

// ----- tb/linear_interp_resampler_tb.sv -----
localparam longint RS_TARGET_HZ = 16000;
localparam longint RS_MIN_HZ    = (RS_TARGET_HZ + 15) / 16;
localparam int     RS_MAX_OUTS  = 32;

typedef struct {
  logic signed [15:0] smp;
  bit                 vld;
  bit                 lst;
} rs_word_t;

// predicts the 16 kHz words for each accepted input word and checks the output
class resample_scoreboard;
  bit [17:0]          rate;
  logic signed [15:0] prev_smp;
  bit                 have_prev;
  bit [17:0]          next_ofs;
  rs_word_t           due_words[$];
  int                 errors;
  int                 n_inputs;
  int                 n_results;
  int                 n_streams;
  int                 n_empty_ends;

  function new();
    rate = 18'd48000;
    clear_stream();
  endfunction

  function void clear_stream();
    prev_smp  = '0;
    have_prev = 1'b0;
    next_ofs  = '0;
  endfunction

  function int pending();
    return due_words.size();
  endfunction

  // blend of two neighbors, rounded half away from zero, saturated
  function logic signed [15:0] interp_value(longint lo_smp, longint hi_smp, longint ofs);
    longint num;
    longint q;
    num = lo_smp * (RS_TARGET_HZ - ofs) + hi_smp * ofs;
    if (num >= 0) q = (num + RS_TARGET_HZ / 2) / RS_TARGET_HZ;
    else q = -((-num + RS_TARGET_HZ / 2) / RS_TARGET_HZ);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function void push(logic signed [15:0] smp, bit vld, bit lst);
    rs_word_t w;
    w.smp = smp;
    w.vld = vld;
    w.lst = lst;
    due_words.push_back(w);
  endfunction

  function void note_input(logic signed [15:0] smp, bit eos);
    longint eff;
    longint ofs;
    int     n;
    int     tail;
    eff = (rate < RS_MIN_HZ) ? RS_MIN_HZ : rate;
    ofs = next_ofs;
    n = 0;
    tail = 0;
    n_inputs++;
    if (have_prev) begin
      while (ofs < RS_TARGET_HZ && n < RS_MAX_OUTS) begin
        push(interp_value(prev_smp, smp, ofs), 1'b1, 1'b0);
        n++;
        ofs += eff;
      end
      ofs = (ofs >= RS_TARGET_HZ) ? ofs - RS_TARGET_HZ : 0;
    end
    if (!eos) begin
      prev_smp  = smp;
      have_prev = 1'b1;
      next_ofs  = ofs[17:0];
      return;
    end
    // flat tail past the final word
    while (ofs < RS_TARGET_HZ && n < RS_MAX_OUTS) begin
      push(smp, 1'b1, 1'b0);
      n++;
      tail++;
      ofs += eff;
    end
    if (tail > 0 || n >= RS_MAX_OUTS) due_words[due_words.size() - 1].lst = 1'b1;
    else begin
      push('0, 1'b0, 1'b1);
      n_empty_ends++;
    end
    n_streams++;
    clear_stream();
  endfunction

  function void check_word(logic signed [15:0] smp, logic vld, logic lst);
    rs_word_t w;
    n_results++;
    if (due_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word: expected none, got sample %0d valid %0b last %0b",
               $time, smp, vld, lst);
      return;
    end
    w = due_words.pop_front();
    if (smp !== w.smp) begin
      errors++;
      $display("%0t: sample_out mismatch: expected %0d, got %0d", $time, w.smp, smp);
    end
    if (vld !== w.vld) begin
      errors++;
      $display("%0t: valid_sample mismatch: expected %0b, got %0b", $time, w.vld, vld);
    end
    if (lst !== w.lst) begin
      errors++;
      $display("%0t: last_out mismatch: expected %0b, got %0b", $time, w.lst, lst);
    end
  endfunction
endclass

module linear_interp_resampler_tb;

  // far above the slowest legal run: every word at 32 results, each held off by the receiver
  localparam int LIMIT = 1_500_000;

  // every input of the block known from time zero
  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 cfg_we = 1'b0;
  logic [lirs_pkg::RATE_W-1:0]          cfg_wdata = '0;
  logic                                 in_valid = 1'b0;
  logic signed [lirs_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic                                 in_end_of_stream = 1'b0;
  logic                                 out_stall = 1'b0;
  logic                                 in_stall;
  logic                                 out_valid;
  logic signed [lirs_pkg::SAMPLE_W-1:0] out_sample_out;
  logic                                 out_valid_sample;
  logic                                 out_last_out;

  resample_scoreboard sb = new();

  // sender idle percentage, changed per phase; zero gives back-to-back words
  int send_idle_pct = 0;
  int n_rates = 1;
  int cycle_count = 0;

  // receiver state, owned by the receiver process alone
  int rx_cycles = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int long_holds = 0;

  always #1 clk = ~clk;

  linear_interp_resampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_valid_sample (out_valid_sample),
    .out_last_out     (out_last_out)
  );

  // both handshakes sampled at the edge, before any driven value moves
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_sample_in, in_end_of_stream);
      if (out_valid && !out_stall) sb.check_word(out_sample_out, out_valid_sample, out_last_out);
    end
  end

  // receiver: stall density is redrawn periodically, with rare bursts
  // and three long hold-offs that let the block back up into its input
  always @(posedge clk) begin
    if (rst_n) begin
      rx_cycles++;
      if (rx_cycles % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      if (rx_cycles == 400 || rx_cycles == 3000 || rx_cycles == 9000) begin
        stall_left = 300;
        long_holds++;
      end else if (stall_left == 0 && $urandom_range(0, 199) == 0) begin
        stall_left = $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("%0t: timed out with %0d result words still due", $time, sb.pending());
      $display("linear_interp_resampler_tb: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    if ($urandom_range(0, 99) >= send_idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // full-range words with the extremes mixed in
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short streams, some medium, the odd long one
  function automatic int stream_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 75) return $urandom_range(2, 8);
    if (r < 95) return $urandom_range(9, 20);
    return $urandom_range(30, 45);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input logic signed [15:0] smp, input logic eos);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_in     <= smp;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_stream(input int len, input bit close);
    for (int i = 0; i < len; i++) send_word(pick_sample(), close && (i == len - 1));
  endtask

  // idle the input, wait for every due word, then leave time for the block
  // to settle back to idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_rate(input logic [lirs_pkg::RATE_W-1:0] rate);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rate = rate;
    n_rates++;
  endtask

  initial begin
    // reset-rate streams of length 1 to 4 hit a lone final word, empty and
    // non-empty tails; then a long stream of extremes and alternating bits
    logic signed [15:0] dir_smp [18];
    bit dir_eos [18];
    // half-way ties at the slowest rate round away from zero both ways
    logic signed [15:0] tie_smp [4];
    logic [lirs_pkg::RATE_W-1:0] phase_rate [10];
    int n_items;
    int len;

    dir_smp = '{
      16'sh7fff,
      16'sh8000, 16'sh7fff,
      16'sh0000, 16'shffff, 16'sh0001,
      16'sh4000, 16'shbfff, 16'sh5555, 16'shaaaa,
      16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
      16'sh0000, 16'shffff, 16'shffff, 16'sh7fff
    };
    dir_eos = '{1, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1};
    tie_smp = '{16'sh0000, 16'sh0001, 16'sh0000, 16'shffff};
    // zero and just under the floor saturate; above 192 kHz up to full scale are used as is
    phase_rate = '{18'd0, 18'd999, 18'd16000, 18'd44100, 18'd8000, 18'd192000,
                   18'd200000, 18'h3ffff, 18'($urandom_range(1000, 192000)), 18'($urandom)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 0;
    for (int i = 0; i < 18; i++) send_word(dir_smp[i], dir_eos[i]);
    wait_drained();
    write_rate(18'd1000);
    for (int i = 0; i < 4; i++) send_word(tie_smp[i], i == 3);

    // random phases, one rate each; a stream is now and then left open across a rate change
    foreach (phase_rate[p]) begin
      wait_drained();
      write_rate(phase_rate[p]);
      case ($urandom_range(0, 3))
        0: send_idle_pct = 0;
        1: send_idle_pct = 10;
        2: send_idle_pct = 30;
        default: send_idle_pct = 60;
      endcase
      n_items = 0;
      while (n_items < 13) begin
        len = stream_len();
        n_items += len;
        send_stream(len, (n_items < 13) || ($urandom_range(0, 3) != 0));
      end
    end
    wait_drained();

    $display("covered %0d input words in %0d closed streams, %0d result words checked",
             sb.n_inputs, sb.n_streams, sb.n_results);
    $display("%0d rate settings incl. zero and full scale, %0d empty stream ends,",
             n_rates, sb.n_empty_ends);
    $display("%0d long hold-offs", long_holds);
    if (sb.errors == 0) begin
      $display("linear_interp_resampler_tb: PASS");
    end else begin
      $display("linear_interp_resampler_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- linear_interp_resampler.f -----
hdl/lirs_pkg.sv
hdl/linear_interp_resampler.sv
tb/linear_interp_resampler_tb.sv
